### src/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types for the descending record sorter: record layout and the
// packed request and response payloads, and the compare-exchange result.
// ----------------------------------------------------------------------------
package bsd_pkg;

   localparam int unsigned KEY_W = 16;
   localparam int unsigned TAG_W = 16;

   // One stored record: key and tag.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [KEY_W-1:0] sort_key;
      logic [TAG_W-1:0] record_tag;
      logic             last_item;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] out_key;
      logic [TAG_W-1:0] out_tag;
      logic             out_last;
      logic             overflow;
   } rsp_type;

   // Result of one compare-exchange step.
   typedef struct packed {
      entry_type wr_entry;
      entry_type carry;
   } swap_type;

endpackage

### src/bubble_sort_descending_top.sv
// ----------------------------------------------------------------------------
// bubble_sort_descending_top
// Collects keyed records, sorts them by key in descending order with stable
// bubble passes over one RAM and one compare-exchange unit, then emits them.
// ----------------------------------------------------------------------------
//
//  channel  | ports                   | handshake
//  ---------+-------------------------+------------------------------------
//  request  | start, busy, req_data   | transfer when start && !busy
//  response | rsp_valid, rsp_data     | one-cycle strobe, no back-pressure
//
//  The closing record (last_item) starts the sort, whose pace is set by
//  the single RAM read port feeding the compare-exchange unit one record
//  per cycle. Emission then reads the stored records out in order. busy is
//  high from the closing transfer until the last read is issued; the final
//  result shows in the first cycle with busy low, so the next set's first
//  record can transfer alongside it.
//  Reset clears the sequencer, record count and overflow flag; the RAM is
//  not cleared (only written entries are ever read).
//  Results cannot be stalled by the receiver.
//
module bubble_sort_descending_top
   import bsd_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int unsigned AW = $clog2(MAX_ITEMS);
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

   // Sequencer states:
   //   LOAD   - idle, accepting records
   //   RD0    - issue read of entry 0 for a new pass
   //   RD1    - entry 0 arrives into the carry; issue read of entry 1
   //   CMP    - compare-exchange carry against entry idx+1, write entry idx
   //   WTOP   - write the carry to the pass's top slot
   //   EMIT   - read entries in order; data is shown the following cycle
   typedef enum logic [2:0] {
      S_LOAD,
      S_RD0,
      S_RD1,
      S_CMP,
      S_WTOP,
      S_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            drop_ff, drop_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [AW-1:0]   top_ff, top_in;
   entry_type       carry_ff, carry_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   // RAM port controls
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   entry_type       rd_data;

   swap_type        swap;
   entry_type       req_entry;
   logic            full;
   logic [CW-1:0]   n_closed;
   logic            req_xfer;

   assign req_entry.key = req_data.sort_key;
   assign req_entry.tag = req_data.record_tag;
   assign full          = (count_ff == CW'(MAX_ITEMS));
   assign n_closed      = full ? count_ff : count_ff + CW'(1);
   assign req_xfer      = start && (state_ff == S_LOAD);

   bsd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bsd_swap_unit u_swap (
      .carry   (carry_ff),
      .fetched (rd_data),
      .result  (swap)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      idx_in       = idx_ff;
      top_in       = top_ff;
      carry_in     = carry_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_entry;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_xfer) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (req_data.last_item) begin
                  idx_in = '0;
                  top_in = AW'(n_closed - CW'(1));
                  // A single record needs no pass.
                  state_in = (n_closed == CW'(1)) ? S_EMIT : S_RD0;
               end
            end
         end

         S_RD0: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_RD1;
         end

         S_RD1: begin
            carry_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'(1);
            idx_in   = '0;
            state_in = S_CMP;
         end

         S_CMP: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = swap.wr_entry;
            carry_in = swap.carry;
            if (({1'b0, idx_ff} + (AW+1)'(1)) < {1'b0, top_ff}) begin
               rd_en   = 1'b1;
               rd_addr = AW'({1'b0, idx_ff} + (AW+1)'(2));
               idx_in  = idx_ff + AW'(1);
            end else begin
               state_in = S_WTOP;
            end
         end

         S_WTOP: begin
            wr_en   = 1'b1;
            wr_addr = top_ff;
            wr_data = carry_ff;
            idx_in  = '0;
            if (top_ff == AW'(1)) begin
               state_in = S_EMIT;
            end else begin
               top_in   = top_ff - AW'(1);
               state_in = S_RD0;
            end
         end

         S_EMIT: begin
            rd_en        = 1'b1;
            rd_addr      = idx_ff;
            rsp_valid_in = 1'b1;
            rsp_ovf_in   = drop_ff;
            rsp_last_in  = ((CW'(idx_ff) + CW'(1)) == count_ff);
            idx_in       = idx_ff + AW'(1);
            if (rsp_last_in) begin
               // Set done: empty the store for the next one.
               count_in = '0;
               drop_in  = 1'b0;
               idx_in   = '0;
               state_in = S_LOAD;
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         idx_ff       <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         rsp_ovf_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         idx_ff       <= idx_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
      carry_ff <= carry_in;
   end

   // Response key and tag come straight from the RAM's read register.
   assign busy              = (state_ff != S_LOAD);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.out_key  = rd_data.key;
   assign rsp_data.out_tag  = rd_data.tag;
   assign rsp_data.out_last = rsp_last_ff;
   assign rsp_data.overflow = rsp_ovf_ff;

endmodule

### src/bsd_ram.sv
// ----------------------------------------------------------------------------
// bsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bsd_swap_unit.sv
// ----------------------------------------------------------------------------
// bsd_swap_unit
// Compare-exchange step of one bubble pass. The carried record sinks while
// the fetched key is strictly larger; equal keys never pass (stable sort).
// ----------------------------------------------------------------------------
module bsd_swap_unit
   import bsd_pkg::*;
(
   input  entry_type carry,
   input  entry_type fetched,
   output swap_type  result
);

   always_comb begin
      if (carry.key < fetched.key) begin
         result.wr_entry = fetched;
         result.carry    = carry;
      end else begin
         result.wr_entry = carry;
         result.carry    = fetched;
      end
   end

endmodule
